// ===== rtl/core/bqc_pkg.sv =====
// package for the biquad cascade filter
// shared constants, function and coefficient codes, accumulator control struct
// no dependencies
package bqc_pkg;

  // default sizes handed to the top level parameters
  localparam int MAX_SECTIONS_DEF = 16;
  localparam int SAMPLE_BITS_DEF  = 24;
  localparam int COEF_BITS_DEF    = 32;

  // fixed field widths
  localparam int COUNT_W   = 5;
  localparam int FUNC_W    = 2;
  localparam int SEC_IDX_W = 4;
  localparam int SEL_W     = 3;
  localparam int LIN_W     = SEC_IDX_W + 3;

  // coefficients per section
  localparam int NUM_COEFS = 5;

  // function codes of an input transaction
  localparam logic [FUNC_W-1:0] FUNC_FILTER = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_COEF   = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // coefficient select codes
  localparam logic [SEL_W-1:0] COEF_B0 = 3'd0;
  localparam logic [SEL_W-1:0] COEF_B1 = 3'd1;
  localparam logic [SEL_W-1:0] COEF_B2 = 3'd2;
  localparam logic [SEL_W-1:0] COEF_A1 = 3'd3;
  localparam logic [SEL_W-1:0] COEF_A2 = 3'd4;

  // accumulator control from the sequencer
  typedef struct packed {
    logic acc_start;
    logic acc_add;
    logic acc_sub;
  } mac_ctrl_t;

endpackage

// ===== rtl/core/bqc_in_if.sv =====
// input channel of the biquad cascade filter: valid/ready plus item payload
// depends on bqc_pkg
interface bqc_in_if #(
  parameter int SAMPLE_BITS = bqc_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS   = bqc_pkg::COEF_BITS_DEF
);
  import bqc_pkg::*;

  logic                        valid;
  logic                        ready;
  logic [FUNC_W-1:0]           func;
  logic signed [SAMPLE_BITS-1:0] sample_in;
  logic [SEC_IDX_W-1:0]        section_index;
  logic [SEL_W-1:0]            coef_select;
  logic signed [COEF_BITS-1:0] coef_value;

  modport source (
    output valid, func, sample_in, section_index, coef_select, coef_value,
    input  ready
  );

  modport sink (
    input  valid, func, sample_in, section_index, coef_select, coef_value,
    output ready
  );
endinterface

// ===== rtl/core/bqc_out_if.sv =====
// output channel of the biquad cascade filter: valid/ready plus result payload
// depends on bqc_pkg
interface bqc_out_if #(
  parameter int SAMPLE_BITS = bqc_pkg::SAMPLE_BITS_DEF
);
  import bqc_pkg::*;

  logic                          valid;
  logic                          ready;
  logic signed [SAMPLE_BITS-1:0] sample_out;
  logic                          saturated;

  modport source (
    output valid, sample_out, saturated,
    input  ready
  );

  modport sink (
    input  valid, sample_out, saturated,
    output ready
  );
endinterface

// ===== rtl/core/bqc_coef_mem.sv =====
// coefficient table: one write port, one registered read port
// entries never written read as their reset value (b0 one, others zero)
module bqc_coef_mem #(
  parameter int DEPTH  = 80,
  parameter int ADDR_W = 7,
  parameter int DATA_W = 32
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic [ADDR_W-1:0] raddr_i,
  input  logic              rb0_i,
  output logic [DATA_W-1:0] rdata_o
);
  import bqc_pkg::*;

  // unity in the coefficient format, four integer bits
  localparam logic [DATA_W-1:0] ONE = DATA_W'(1) << (DATA_W - 4);

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_vld_q;
  logic              rd_b0_q;

  // storage array
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rd_data_q <= mem_q[raddr_i];
    rd_vld_q  <= vld_q[raddr_i];
    rd_b0_q   <= rb0_i;
  end

  // written flags, cleared by reset
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  // unwritten entries fall back to the bypass value
  assign rdata_o = rd_vld_q ? rd_data_q : (rd_b0_q ? ONE : '0);

endmodule

// ===== rtl/core/bqc_hist_mem.sv =====
// section history memory: one row {x1, x2, y1, y2} per section
// rows not written since reset or the last clear read as zero
module bqc_hist_mem #(
  parameter int DEPTH  = 16,
  parameter int ADDR_W = 4,
  parameter int DATA_W = 96
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              clr_i,
  input  logic              we_i,
  input  logic [ADDR_W-1:0] waddr_i,
  input  logic [DATA_W-1:0] wdata_i,
  input  logic              re_i,
  input  logic [ADDR_W-1:0] raddr_i,
  output logic [DATA_W-1:0] rdata_o
);
  import bqc_pkg::*;

  logic [DATA_W-1:0] mem_q [DEPTH];
  logic [DEPTH-1:0]  vld_q;
  logic [DATA_W-1:0] rd_data_q;
  logic              rd_vld_q;

  // storage array, read only on request so the row holds for the section
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rd_data_q <= mem_q[raddr_i];
      rd_vld_q  <= vld_q[raddr_i];
    end
  end

  // row valid flags, a clear drops them all at once
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clr_i) begin
      vld_q <= '0;
    end else if (we_i) begin
      vld_q[waddr_i] <= 1'b1;
    end
  end

  assign rdata_o = rd_vld_q ? rd_data_q : '0;

endmodule

// ===== rtl/core/bqc_mac.sv =====
// shared multiply-accumulate unit with rounding offset and saturation
// depends on bqc_pkg for the control struct
module bqc_mac #(
  parameter int SAMPLE_BITS = 24,
  parameter int COEF_BITS   = 32
) (
  input  logic                          clk_i,
  input  bqc_pkg::mac_ctrl_t            ctrl_i,
  input  logic signed [SAMPLE_BITS-1:0] sample_i,
  input  logic signed [COEF_BITS-1:0]   coef_i,
  output logic signed [SAMPLE_BITS-1:0] y_o,
  output logic                          clip_o
);
  import bqc_pkg::*;

  localparam int PROD_W = SAMPLE_BITS + COEF_BITS;
  localparam int ACC_W  = PROD_W + 3;
  localparam int FRAC_W = COEF_BITS - 4;
  localparam int RES_W  = ACC_W - FRAC_W;
  localparam int TOP_W  = RES_W - SAMPLE_BITS + 1;
  localparam logic [ACC_W-1:0] HALF = ACC_W'(1) << (FRAC_W - 1);

  logic signed [PROD_W-1:0] prod_q;
  logic [ACC_W-1:0]         prod_ext;
  logic [ACC_W-1:0]         acc_d;
  logic [ACC_W-1:0]         acc_q;
  logic [RES_W-1:0]         res;
  logic [TOP_W-1:0]         res_top;

  // product register
  always_ff @(posedge clk_i) begin
    prod_q <= sample_i * coef_i;
  end

  // accumulator, seeded with the rounding half so the finish is a plain shift
  assign prod_ext = {{3{prod_q[PROD_W-1]}}, prod_q};

  always_comb begin
    acc_d = acc_q;
    if (ctrl_i.acc_start) begin
      acc_d = HALF + prod_ext;
    end else if (ctrl_i.acc_add) begin
      acc_d = acc_q + prod_ext;
    end else if (ctrl_i.acc_sub) begin
      acc_d = acc_q - prod_ext;
    end
  end

  always_ff @(posedge clk_i) begin
    acc_q <= acc_d;
  end

  // shift down and clip to the sample width
  assign res     = acc_q[ACC_W-1:FRAC_W];
  assign res_top = res[RES_W-1:SAMPLE_BITS-1];
  assign clip_o  = !((&res_top) || (~|res_top));
  assign y_o     = clip_o ? {res[RES_W-1], {(SAMPLE_BITS-1){~res[RES_W-1]}}}
                          : res[SAMPLE_BITS-1:0];

endmodule

// ===== rtl/core/biquad_cascade_filter.sv =====
// Cascade of direct-form-I biquad sections sharing one multiply-accumulate unit.
// A filter transaction takes a sample through the n sections in use (the section
// count register, capped at MAX_SECTIONS) and hands the result to the output
// register once that is free. Each section steps through fetch, multiply b0,
// accumulate b0, b1, b2, a1, a2 and finish with write-back; the single multiplier
// takes the five coefficients one per cycle behind the registered coefficient and
// history reads. Coefficient-write and clear transactions give no result. The
// input is not ready while a sample is being filtered or handed over. No clearing
// pass follows reset: coefficient table and history come up in bypass state.
module biquad_cascade_filter #(
  parameter int MAX_SECTIONS = bqc_pkg::MAX_SECTIONS_DEF,
  parameter int SAMPLE_BITS  = bqc_pkg::SAMPLE_BITS_DEF,
  parameter int COEF_BITS    = bqc_pkg::COEF_BITS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [bqc_pkg::COUNT_W-1:0]   cfg_data_i,
  bqc_in_if.sink                        in_if,
  bqc_out_if.source                     out_if
);
  import bqc_pkg::*;

  localparam int SEC_W      = (MAX_SECTIONS > 1) ? $clog2(MAX_SECTIONS) : 1;
  localparam int CNT_W      = $clog2(MAX_SECTIONS + 1);
  localparam int COEF_DEPTH = MAX_SECTIONS * NUM_COEFS;
  localparam int CA_W       = $clog2(COEF_DEPTH);
  localparam int ROW_W      = 4 * SAMPLE_BITS;

  // phases of one section
  localparam logic [2:0] PH_FETCH  = 3'd0;
  localparam logic [2:0] PH_MUL_B0 = 3'd1;
  localparam logic [2:0] PH_ACC_B0 = 3'd2;
  localparam logic [2:0] PH_ACC_B1 = 3'd3;
  localparam logic [2:0] PH_ACC_B2 = 3'd4;
  localparam logic [2:0] PH_ACC_A1 = 3'd5;
  localparam logic [2:0] PH_ACC_A2 = 3'd6;
  localparam logic [2:0] PH_FINISH = 3'd7;

  typedef enum logic [1:0] {
    S_IDLE,
    S_RUN,
    S_DONE
  } state_e;

  state_e                  state_q, state_d;
  logic [2:0]              ph_q, ph_d;
  logic [CNT_W-1:0]        sec_q, sec_d;
  logic [CNT_W-1:0]        n_q, n_d;
  logic [CA_W-1:0]         base_q, base_d;
  logic [SAMPLE_BITS-1:0]  x_q, x_d;
  logic                    sat_q, sat_d;
  logic                    out_valid_q, out_valid_d;
  logic [SAMPLE_BITS-1:0]  out_sample_q, out_sample_d;
  logic                    out_sat_q, out_sat_d;
  logic [COUNT_W-1:0]      count_q;

  logic                    in_fire;
  logic                    out_fire;
  logic [CNT_W-1:0]        n_eff;
  logic [LIN_W-1:0]        wr_lin;
  logic                    wr_ok;
  logic                    coef_we;
  logic [CA_W-1:0]         coef_raddr;
  logic                    coef_rb0;
  logic signed [COEF_BITS-1:0] coef_rd;
  logic                    hist_clr;
  logic                    hist_re;
  logic                    hist_we;
  logic [ROW_W-1:0]        hist_rd;
  logic [ROW_W-1:0]        hist_wr;
  logic [SAMPLE_BITS-1:0]  hx1, hx2, hy1, hy2;
  logic signed [SAMPLE_BITS-1:0] mul_sample;
  logic signed [SAMPLE_BITS-1:0] y;
  logic                    clip;
  mac_ctrl_t               mac_ctrl;

  // handshakes
  assign in_fire  = in_if.valid && in_if.ready;
  assign out_fire = out_if.valid && out_if.ready;

  assign in_if.ready       = (state_q == S_IDLE);
  assign out_if.valid      = out_valid_q;
  assign out_if.sample_out = out_sample_q;
  assign out_if.saturated  = out_sat_q;

  // section count register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (cfg_we_i) begin
      count_q <= cfg_data_i;
    end
  end

  // sections in use, capped at the table size
  always_comb begin
    if (32'(count_q) > 32'(MAX_SECTIONS)) begin
      n_eff = CNT_W'(MAX_SECTIONS);
    end else begin
      n_eff = CNT_W'(count_q);
    end
  end

  // coefficient write address and range check
  assign wr_lin = ({3'b000, in_if.section_index} << 2) + {3'b000, in_if.section_index}
                + {4'b0000, in_if.coef_select};
  assign wr_ok  = (32'(in_if.section_index) < 32'(MAX_SECTIONS))
               && (in_if.coef_select <= COEF_A2);

  // coefficient reads run one phase ahead of the multiplier
  assign coef_raddr = base_q + CA_W'(ph_q);
  assign coef_rb0   = (ph_q == PH_FETCH);

  // history row fields and the shifted row written back
  assign hx1     = hist_rd[4*SAMPLE_BITS-1:3*SAMPLE_BITS];
  assign hx2     = hist_rd[3*SAMPLE_BITS-1:2*SAMPLE_BITS];
  assign hy1     = hist_rd[2*SAMPLE_BITS-1:SAMPLE_BITS];
  assign hy2     = hist_rd[SAMPLE_BITS-1:0];
  assign hist_wr = {x_q, hx1, y, hy1};

  // multiplier operand and accumulator control per phase
  always_comb begin
    mac_ctrl = '0;
    case (ph_q)
      PH_MUL_B0: mul_sample = x_q;
      PH_ACC_B0: mul_sample = hx1;
      PH_ACC_B1: mul_sample = hx2;
      PH_ACC_B2: mul_sample = hy1;
      default:   mul_sample = hy2;
    endcase
    if (state_q == S_RUN) begin
      case (ph_q)
        PH_ACC_B0: mac_ctrl.acc_start = 1'b1;
        PH_ACC_B1: mac_ctrl.acc_add   = 1'b1;
        PH_ACC_B2: mac_ctrl.acc_add   = 1'b1;
        PH_ACC_A1: mac_ctrl.acc_sub   = 1'b1;
        PH_ACC_A2: mac_ctrl.acc_sub   = 1'b1;
        default:   mac_ctrl = '0;
      endcase
    end
  end

  // sequencer next state
  always_comb begin
    state_d      = state_q;
    ph_d         = ph_q;
    sec_d        = sec_q;
    n_d          = n_q;
    base_d       = base_q;
    x_d          = x_q;
    sat_d        = sat_q;
    out_valid_d  = out_valid_q;
    out_sample_d = out_sample_q;
    out_sat_d    = out_sat_q;
    coef_we      = 1'b0;
    hist_clr     = 1'b0;
    hist_re      = 1'b0;
    hist_we      = 1'b0;
    if (out_fire) begin
      out_valid_d = 1'b0;
    end
    case (state_q)
      S_IDLE: begin
        if (in_fire) begin
          case (in_if.func)
            FUNC_FILTER: begin
              x_d     = in_if.sample_in;
              sat_d   = 1'b0;
              sec_d   = '0;
              base_d  = '0;
              ph_d    = PH_FETCH;
              n_d     = n_eff;
              state_d = (n_eff == '0) ? S_DONE : S_RUN;
            end
            FUNC_COEF: begin
              coef_we = wr_ok;
            end
            FUNC_CLEAR: begin
              hist_clr = 1'b1;
            end
            default: begin
            end
          endcase
        end
      end
      S_RUN: begin
        hist_re = (ph_q == PH_FETCH);
        ph_d    = ph_q + 3'd1;
        if (ph_q == PH_FINISH) begin
          hist_we = 1'b1;
          x_d     = y;
          sat_d   = sat_q | clip;
          sec_d   = sec_q + CNT_W'(1);
          base_d  = base_q + CA_W'(NUM_COEFS);
          ph_d    = PH_FETCH;
          if (CNT_W'(sec_q + CNT_W'(1)) == n_q) begin
            state_d = S_DONE;
          end
        end
      end
      S_DONE: begin
        if (!out_valid_q || out_if.ready) begin
          out_valid_d  = 1'b1;
          out_sample_d = x_q;
          out_sat_d    = sat_q;
          state_d      = S_IDLE;
        end
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // sequencer state and output register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= S_IDLE;
      ph_q         <= PH_FETCH;
      sec_q        <= '0;
      n_q          <= '0;
      base_q       <= '0;
      x_q          <= '0;
      sat_q        <= 1'b0;
      out_valid_q  <= 1'b0;
      out_sample_q <= '0;
      out_sat_q    <= 1'b0;
    end else begin
      state_q      <= state_d;
      ph_q         <= ph_d;
      sec_q        <= sec_d;
      n_q          <= n_d;
      base_q       <= base_d;
      x_q          <= x_d;
      sat_q        <= sat_d;
      out_valid_q  <= out_valid_d;
      out_sample_q <= out_sample_d;
      out_sat_q    <= out_sat_d;
    end
  end

  // coefficient table
  bqc_coef_mem #(
    .DEPTH  (COEF_DEPTH),
    .ADDR_W (CA_W),
    .DATA_W (COEF_BITS)
  ) u_coef_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .we_i    (coef_we),
    .waddr_i (CA_W'(wr_lin)),
    .wdata_i (in_if.coef_value),
    .raddr_i (coef_raddr),
    .rb0_i   (coef_rb0),
    .rdata_o (coef_rd)
  );

  // section history
  bqc_hist_mem #(
    .DEPTH  (MAX_SECTIONS),
    .ADDR_W (SEC_W),
    .DATA_W (ROW_W)
  ) u_hist_mem (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .clr_i   (hist_clr),
    .we_i    (hist_we),
    .waddr_i (sec_q[SEC_W-1:0]),
    .wdata_i (hist_wr),
    .re_i    (hist_re),
    .raddr_i (sec_q[SEC_W-1:0]),
    .rdata_o (hist_rd)
  );

  // shared multiply-accumulate unit
  bqc_mac #(
    .SAMPLE_BITS (SAMPLE_BITS),
    .COEF_BITS   (COEF_BITS)
  ) u_mac (
    .clk_i    (clk_i),
    .ctrl_i   (mac_ctrl),
    .sample_i (mul_sample),
    .coef_i   (coef_rd),
    .y_o      (y),
    .clip_o   (clip)
  );

  // section counter stays below the sections in use while running
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN) |-> (sec_q < n_q))
    else $error("section counter beyond sections in use");

  // the last section's write-back leads straight to result hand-over
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_RUN && ph_q == PH_FINISH && CNT_W'(sec_q + CNT_W'(1)) == n_q)
      |=> (state_q == S_DONE))
    else $error("last section did not end the transaction");

  // a result is only loaded from the hand-over state
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == S_DONE))
    else $error("result loaded outside hand-over");

  // the clip flag only drops when a new sample is taken
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $fell(sat_q) |-> $past(in_fire))
    else $error("clip flag lost during a transaction");

endmodule
